// ===== design/pfvf_pkg.sv =====
// ----------------------------------------------------------------------------
// pfvf_pkg
// Shared types, constants and the fade curve table of the PCM fade and
// volume formatter.
// ----------------------------------------------------------------------------
package pfvf_pkg;

    // Fade curve resolution: index bits taken from the top of the phase
    localparam int CURVE_INDEX_BITS = 6;
    localparam int CURVE_POINTS     = 1 << CURVE_INDEX_BITS;
    localparam int BASE_POINTS      = 64;
    localparam int BASE_SHIFT       = 6;
    localparam int FRAC_BITS        = 16;

    // Bit-serial multiplier: one multiplier bit per cycle, with a load step
    // before the bit steps and a settle step after them
    localparam int MUL_BITS     = 16;
    localparam int MUL_CNT_BITS = $clog2(MUL_BITS + 2);
    localparam logic [MUL_CNT_BITS-1:0] MUL_DONE = MUL_CNT_BITS'(MUL_BITS + 1);

    // Configuration register indexes
    localparam int CFG_INDEX_BITS = 3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SAMPLE_FORMAT = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FORCE_MONO    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FADER_STEP    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GAIN_LEFT     = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GAIN_RIGHT    = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INTERNAL_DAC  = 3'd5;

    // Input opcodes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // Reset values and fixed levels
    localparam logic [31:0] STEP_RESET = 32'h0001_0000;
    localparam logic [15:0] GAIN_RESET = 16'hFFFF;
    localparam logic [31:0] PHASE_MAX  = 32'hFFFF_FFFF;
    localparam logic [15:0] FADE_FULL  = 16'h8000;

    typedef enum logic [1:0] {
        FMT_8_MONO,
        FMT_8_STEREO,
        FMT_16_MONO,
        FMT_16_STEREO
    } t_format;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CURVE,
        ST_FADE,
        ST_GAIN,
        ST_HI,
        ST_PUT
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_mul_ctrl;

    // Base fade curve, 65 points rising from zero to full scale
    localparam logic [15:0] BASE_CURVE [0:64] = '{
        16'h0000, 16'h0196, 16'h033e, 16'h04f9, 16'h06c6, 16'h08a5, 16'h0a96, 16'h0c97,
        16'h0ea9, 16'h10ca, 16'h12fc, 16'h153a, 16'h1788, 16'h19e4, 16'h1c4b, 16'h1ebe,
        16'h213c, 16'h23c4, 16'h2656, 16'h28f0, 16'h2b90, 16'h2e38, 16'h30e5, 16'h3396,
        16'h364b, 16'h3902, 16'h3bbb, 16'h3e74, 16'h412c, 16'h43e2, 16'h4695, 16'h4944,
        16'h4bee, 16'h4e92, 16'h512f, 16'h53c3, 16'h564e, 16'h58ce, 16'h5b42, 16'h5daa,
        16'h6005, 16'h6250, 16'h648c, 16'h66b8, 16'h68d2, 16'h6ad9, 16'h6ccd, 16'h6eac,
        16'h7078, 16'h722c, 16'h73cc, 16'h7552, 16'h76c2, 16'h7818, 16'h7956, 16'h7a7a,
        16'h7b83, 16'h7c72, 16'h7d46, 16'h7dfe, 16'h7e9a, 16'h7f1b, 16'h7f7f, 16'h7fff,
        16'h8000
    };

    // Curve point p, resampled from the base curve (linear, rounded down)
    function automatic logic [15:0] f_curve(input logic [CURVE_INDEX_BITS:0] p);
        logic [CURVE_INDEX_BITS+BASE_SHIFT:0] num;
        logic [6:0]                           base_idx;
        logic [CURVE_INDEX_BITS-1:0]          rem_part;
        logic [15:0]                          a_val;
        logic [15:0]                          b_val;
        logic [CURVE_INDEX_BITS+15:0]         delta;
        num      = {p, BASE_SHIFT'(0)};
        base_idx = 7'(num >> CURVE_INDEX_BITS);
        rem_part = num[CURVE_INDEX_BITS-1:0];
        a_val    = BASE_CURVE[base_idx];
        b_val    = (base_idx < 7'(BASE_POINTS)) ? BASE_CURVE[base_idx + 7'd1] : a_val;
        delta    = (CURVE_INDEX_BITS+16)'(b_val - a_val)
                 * (CURVE_INDEX_BITS+16)'(rem_part);
        return a_val + 16'(delta >> CURVE_INDEX_BITS);
    endfunction

endpackage

// ===== design/pcm_fade_volume_formatter_core.sv =====
// ----------------------------------------------------------------------------
// pcm_fade_volume_formatter_core
// Unpacks PCM source items, applies the fade-in curve, channel gain and DAC
// bias, and emits stereo 16-bit DAC words; fade-out ticks ramp the bias or rearm the fade-in.
// ----------------------------------------------------------------------------
// Each multiply round on the two bit-serial multipliers has a load step,
// 16 multiplier bit steps and a settle step. A faded sample runs the curve,
// fade and gain rounds before it fills the output register, an unfaded sample
// the gain round alone, a ramping fade-out tick the curve round; 8-bit mono
// adds a round for its second word. The next item is taken once the last word is loaded.
// Reset (synchronous): control, configuration and fade registers to defaults, fade-in pending.
module pcm_fade_volume_formatter_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input items
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_opcode,
    input  logic signed [15:0]    i_word_first,
    input  logic signed [15:0]    i_word_second,
    // result items
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [15:0]           o_left_word,
    output logic [15:0]           o_right_word,
    output logic                  o_last_of_run,
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [pfvf_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [31:0]           i_cfg_data
);

    localparam int CIB = pfvf_pkg::CURVE_INDEX_BITS;

    // Configuration registers
    pfvf_pkg::t_format r_fmt;
    logic              r_fm;
    logic [31:0]       r_step;
    logic [15:0]       r_gl;
    logic [15:0]       r_gr;
    logic              r_idac;

    // Fade state
    logic [31:0]       r_phase;
    logic              r_active;
    logic [15:0]       r_bias;

    // Control
    pfvf_pkg::t_state  r_state;
    pfvf_pkg::t_state  n_state;
    logic [pfvf_pkg::MUL_CNT_BITS-1:0] r_cnt;
    logic              r_opcode;
    logic              r_twice;
    logic              r_second;
    logic              r_out_valid;
    logic              n_out_valid;

    // Item payload
    logic signed [15:0] r_l;
    logic signed [15:0] r_r;
    logic signed [15:0] r_hi;
    logic [15:0]        r_fade;
    logic [15:0]        r_left;
    logic [15:0]        r_right;
    logic               r_last;

    logic               in_accept;
    logic               cfg_accept;
    logic               out_free;
    logic               out_load;
    logic               mul_state;
    logic               mul_done;
    pfvf_pkg::t_mul_ctrl mul_ctrl;

    // Unpack
    logic signed [15:0] lo8;
    logic signed [15:0] hi8;
    logic signed [15:0] sel_l;
    logic signed [15:0] sel_r;
    logic signed [16:0] avg_sum;
    logic signed [15:0] u_l;
    logic signed [15:0] u_r;

    // Curve lookup
    logic [CIB-1:0]     cv_idx;
    logic [15:0]        cv_frac;
    logic [15:0]        cv_lo;
    logic [15:0]        cv_up;
    logic               ph_gt_step;
    logic               ph_lt_room;

    // Multiplier lanes
    logic signed [16:0] a0;
    logic signed [16:0] a1;
    logic [15:0]        b0;
    logic [15:0]        b1;
    logic [33:0]        prod0;
    logic [33:0]        prod1;
    logic [15:0]        fade_sum;
    logic [15:0]        word_l;
    logic [15:0]        word_r;

    assign in_accept  = i_in_valid && o_in_ready;
    assign cfg_accept = i_cfg_valid && o_cfg_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign mul_state  = (r_state == pfvf_pkg::ST_CURVE) || (r_state == pfvf_pkg::ST_FADE)
                     || (r_state == pfvf_pkg::ST_GAIN) || (r_state == pfvf_pkg::ST_HI);
    assign mul_done   = mul_state && (r_cnt == pfvf_pkg::MUL_DONE);

    // Split the source word into left, right and second-half samples
    always_comb begin
        lo8 = {~i_word_first[7], i_word_first[6:0], 8'h00};
        hi8 = {~i_word_first[15], i_word_first[14:8], 8'h00};
        case (r_fmt)
            pfvf_pkg::FMT_8_MONO: begin
                sel_r = lo8;
                sel_l = lo8;
            end
            pfvf_pkg::FMT_8_STEREO: begin
                sel_r = lo8;
                sel_l = hi8;
            end
            pfvf_pkg::FMT_16_MONO: begin
                sel_r = i_word_first;
                sel_l = i_word_first;
            end
            default: begin
                sel_r = i_word_first;
                sel_l = i_word_second;
            end
        endcase
        avg_sum = {sel_r[15], sel_r} + {sel_l[15], sel_l};
        if (r_fm && (r_fmt inside {pfvf_pkg::FMT_8_STEREO, pfvf_pkg::FMT_16_STEREO})) begin
            u_r = avg_sum[16:1];
            u_l = avg_sum[16:1];
        end else begin
            u_r = sel_r;
            u_l = sel_l;
        end
    end

    // Curve points around the phase and the fade window compares
    assign cv_idx     = r_phase[31 -: CIB];
    assign cv_frac    = r_phase[31-CIB -: pfvf_pkg::FRAC_BITS];
    assign cv_lo      = pfvf_pkg::f_curve({1'b0, cv_idx});
    assign cv_up      = pfvf_pkg::f_curve({1'b0, cv_idx} + (CIB+1)'(1));
    assign ph_gt_step = r_phase > r_step;
    assign ph_lt_room = r_phase < ~r_step;

    // Multiplier lanes: left on lane 0, right on lane 1 (curve round: lower/upper point)
    pfvf_serial_mul u_mul0 (
        .i_clk  (i_clk),
        .i_ctrl (mul_ctrl),
        .i_a    (a0),
        .i_b    (b0),
        .o_prod (prod0)
    );

    pfvf_serial_mul u_mul1 (
        .i_clk  (i_clk),
        .i_ctrl (mul_ctrl),
        .i_a    (a1),
        .i_b    (b1),
        .o_prod (prod1)
    );

    assign fade_sum = prod0[31:16] + prod1[31:16];
    assign word_l   = prod0[31:16] + r_bias;
    assign word_r   = prod1[31:16] + r_bias;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pfvf_pkg::ST_IDLE: begin
                if (in_accept) begin
                    if (i_opcode == pfvf_pkg::OP_TICK) begin
                        n_state = ph_gt_step ? pfvf_pkg::ST_CURVE : pfvf_pkg::ST_IDLE;
                    end else if (r_active && ph_lt_room) begin
                        n_state = pfvf_pkg::ST_CURVE;
                    end else begin
                        n_state = pfvf_pkg::ST_GAIN;
                    end
                end
            end
            pfvf_pkg::ST_CURVE: begin
                if (mul_done) begin
                    n_state = (r_opcode == pfvf_pkg::OP_TICK) ? pfvf_pkg::ST_PUT
                                                               : pfvf_pkg::ST_FADE;
                end
            end
            pfvf_pkg::ST_FADE: begin
                if (mul_done) begin
                    n_state = pfvf_pkg::ST_GAIN;
                end
            end
            pfvf_pkg::ST_GAIN, pfvf_pkg::ST_HI: begin
                if (mul_done) begin
                    n_state = pfvf_pkg::ST_PUT;
                end
            end
            pfvf_pkg::ST_PUT: begin
                if (out_free) begin
                    n_state = (r_twice && !r_second) ? pfvf_pkg::ST_HI : pfvf_pkg::ST_IDLE;
                end
            end
            default: n_state = pfvf_pkg::ST_IDLE;
        endcase
    end

    // Control strobes and multiplier operands
    always_comb begin
        o_in_ready    = (r_state == pfvf_pkg::ST_IDLE);
        out_load      = (r_state == pfvf_pkg::ST_PUT) && out_free;
        mul_ctrl.load = mul_state && (r_cnt == '0);
        mul_ctrl.step = mul_state && (r_cnt != '0) && (r_cnt != pfvf_pkg::MUL_DONE);
        case (r_state)
            pfvf_pkg::ST_CURVE: begin
                a0 = {1'b0, cv_lo};
                b0 = ~cv_frac;
                a1 = {1'b0, cv_up};
                b1 = cv_frac;
            end
            pfvf_pkg::ST_FADE: begin
                a0 = {r_l[15], r_l};
                b0 = r_fade;
                a1 = {r_r[15], r_r};
                b1 = r_fade;
            end
            pfvf_pkg::ST_GAIN: begin
                a0 = {r_l[15], r_l};
                b0 = r_gl;
                a1 = {r_r[15], r_r};
                b1 = r_gr;
            end
            default: begin
                a0 = {r_hi[15], r_hi};
                b0 = r_gl;
                a1 = {r_hi[15], r_hi};
                b1 = r_gr;
            end
        endcase
    end

    // Hold the result until its transfer
    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // State, round counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pfvf_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (mul_done || !mul_state) begin
                r_cnt <= '0;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt  <= pfvf_pkg::FMT_16_STEREO;
            r_fm   <= 1'b0;
            r_step <= pfvf_pkg::STEP_RESET;
            r_gl   <= pfvf_pkg::GAIN_RESET;
            r_gr   <= pfvf_pkg::GAIN_RESET;
            r_idac <= 1'b0;
        end else if (cfg_accept) begin
            case (i_cfg_index)
                pfvf_pkg::CFG_SAMPLE_FORMAT: r_fmt  <= pfvf_pkg::t_format'(i_cfg_data[1:0]);
                pfvf_pkg::CFG_FORCE_MONO:    r_fm   <= i_cfg_data[0];
                pfvf_pkg::CFG_FADER_STEP:    r_step <= i_cfg_data;
                pfvf_pkg::CFG_GAIN_LEFT:     r_gl   <= i_cfg_data[15:0];
                pfvf_pkg::CFG_GAIN_RIGHT:    r_gr   <= i_cfg_data[15:0];
                pfvf_pkg::CFG_INTERNAL_DAC:  r_idac <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Fade phase, fade-in flag and DAC bias
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= '0;
            r_active <= 1'b1;
            r_bias   <= '0;
        end else begin
            if (in_accept) begin
                if (i_opcode == pfvf_pkg::OP_TICK) begin
                    // tick at the bottom of the curve: rearm the fade-in
                    if (!ph_gt_step) begin
                        r_phase  <= '0;
                        r_active <= 1'b1;
                        r_bias   <= '0;
                    end
                end else if (r_active && !ph_lt_room) begin
                    // fade-in finished: saturate and switch off
                    r_phase  <= pfvf_pkg::PHASE_MAX;
                    r_active <= 1'b0;
                    if (r_idac) begin
                        r_bias <= pfvf_pkg::FADE_FULL;
                    end
                end
            end
            if ((r_state == pfvf_pkg::ST_CURVE) && mul_done) begin
                if (r_opcode == pfvf_pkg::OP_TICK) begin
                    r_bias  <= fade_sum;
                    r_phase <= r_phase - r_step;
                end else begin
                    r_phase <= r_phase + r_step;
                    if (r_idac) begin
                        r_bias <= fade_sum;
                    end
                end
            end
        end
    end

    // Item flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opcode <= pfvf_pkg::OP_SAMPLE;
            r_twice  <= 1'b0;
            r_second <= 1'b0;
        end else if (in_accept) begin
            r_opcode <= i_opcode;
            r_twice  <= (i_opcode == pfvf_pkg::OP_SAMPLE) && (r_fmt == pfvf_pkg::FMT_8_MONO);
            r_second <= 1'b0;
        end else if (out_load && r_twice) begin
            r_second <= 1'b1;
        end
    end

    // Samples and fade value
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_l  <= u_l;
            r_r  <= u_r;
            r_hi <= hi8;
        end else if ((r_state == pfvf_pkg::ST_FADE) && mul_done) begin
            r_l <= prod0[30:15];
            r_r <= prod1[30:15];
        end
        if ((r_state == pfvf_pkg::ST_CURVE) && mul_done) begin
            r_fade <= fade_sum;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            if (r_opcode == pfvf_pkg::OP_TICK) begin
                r_left  <= r_bias;
                r_right <= r_bias;
            end else begin
                r_left  <= word_l;
                r_right <= word_r;
            end
            r_last <= !(r_twice && !r_second);
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign o_out_valid   = r_out_valid;
    assign o_left_word   = r_left;
    assign o_right_word  = r_right;
    assign o_last_of_run = r_last;

`ifndef SYNTHESIS
    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pfvf_pkg::ST_IDLE || r_state == pfvf_pkg::ST_PUT) |-> (r_cnt == '0))
        else $error("round counter running outside a multiply round");

    a_second_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_twice && !r_second) |=> (r_state == pfvf_pkg::ST_HI) && r_second)
        else $error("8-bit mono first word not followed by second-word round");

    a_fade_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pfvf_pkg::ST_FADE) |-> (r_opcode == pfvf_pkg::OP_SAMPLE))
        else $error("fade round entered for a fade-out tick");

    a_hi_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pfvf_pkg::ST_HI) |-> (r_twice && r_second))
        else $error("second-word round outside 8-bit mono");

    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == pfvf_pkg::ST_PUT))
        else $error("result valid raised outside the put state");
`endif

endmodule

// ===== design/pfvf_serial_mul.sv =====
// ----------------------------------------------------------------------------
// pfvf_serial_mul
// Bit-serial shift-add multiplier: signed 17-bit multiplicand times unsigned
// 16-bit multiplier, one multiplier bit per cycle while the step strobe is high, LSB first.
// ----------------------------------------------------------------------------
module pfvf_serial_mul (
    input  logic                i_clk,
    input  pfvf_pkg::t_mul_ctrl i_ctrl,
    input  logic signed [16:0]  i_a,
    input  logic [15:0]         i_b,
    output logic [33:0]         o_prod
);

    logic signed [16:0] r_a;
    logic signed [17:0] r_hi;
    logic [15:0]        r_lo;
    logic signed [17:0] add_sum;

    // Add the multiplicand when the current multiplier bit is set
    always_comb begin
        add_sum = r_lo[0] ? (r_hi + {r_a[16], r_a}) : r_hi;
    end

    // Load operands, then shift the partial product right one bit a cycle while the step strobe is high
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_a  <= i_a;
            r_hi <= '0;
            r_lo <= i_b;
        end else if (i_ctrl.step) begin
            r_hi <= {add_sum[17], add_sum[17:1]};
            r_lo <= {add_sum[0], r_lo[15:1]};
        end
    end

    assign o_prod = {r_hi, r_lo};

endmodule

// ===== test/pfvf_dac_word_checker.sv =====
// ----------------------------------------------------------------------------
// pfvf_dac_word_checker
// Watches the item, result and register write channels of the PCM fade and
// volume formatter. It keeps its own copy of the fade state and settings,
// predicts the DAC words of each input transfer and compares every result
// transfer, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module pfvf_dac_word_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input item channel
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic                                i_opcode,
    input  logic [15:0]                         i_word_first,
    input  logic [15:0]                         i_word_second,
    // result channel
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic [15:0]                         i_left_word,
    input  logic [15:0]                         i_right_word,
    input  logic                                i_last_of_run,
    // register write channel
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [pfvf_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [31:0]                         i_cfg_data,
    // status toward the testbench top
    output int                                  o_fail_count,
    output int                                  o_pending
);

    localparam int LOW_BITS   = 32 - pfvf_pkg::CURVE_INDEX_BITS;
    localparam int FRAC_SHIFT = 16 - pfvf_pkg::CURVE_INDEX_BITS;

    typedef struct packed {
        logic [15:0] left_word;
        logic [15:0] right_word;
        logic        last_of_run;
    } t_dac_word;

    t_dac_word   expected_words [$];
    logic [15:0] curve_pts [0:pfvf_pkg::CURVE_POINTS];

    // settings copy
    pfvf_pkg::t_format fmt_cfg;
    logic        mono_mix;
    logic [31:0] step_cfg;
    logic [15:0] gain_l;
    logic [15:0] gain_r;
    logic        track_bias;

    // fade state copy
    logic [31:0] phase_acc;
    logic        fading;
    logic [15:0] bias_level;

    int          fail_total;

    // Resample the base curve onto the index grid, rounding down
    initial begin : build_curve
        int num;
        int bi;
        int rm;
        int a;
        int b;
        for (int p = 0; p <= pfvf_pkg::CURVE_POINTS; p++) begin
            num = p * pfvf_pkg::BASE_POINTS;
            bi  = num / pfvf_pkg::CURVE_POINTS;
            rm  = num % pfvf_pkg::CURVE_POINTS;
            a   = pfvf_pkg::BASE_CURVE[bi];
            b   = (bi < pfvf_pkg::BASE_POINTS) ? pfvf_pkg::BASE_CURVE[bi + 1] : a;
            curve_pts[p] = 16'(a + ((b - a) * rm) / pfvf_pkg::CURVE_POINTS);
        end
    end

    // Interpolated curve level at a phase: top bits index, next 16 bits weight
    function automatic logic [15:0] curve_level(logic [31:0] ph);
        logic [pfvf_pkg::CURVE_INDEX_BITS:0] pt;
        longint unsigned frac;
        longint unsigned lvl;
        pt   = {1'b0, ph[31 -: pfvf_pkg::CURVE_INDEX_BITS]};
        frac = longint'(ph[LOW_BITS-1:0]) >> FRAC_SHIFT;
        lvl  = (curve_pts[pt] * (64'hFFFF - frac)) >> 16;
        lvl += (curve_pts[pt + 1'b1] * frac) >> 16;
        return lvl[15:0];
    endfunction

    // Q16 gain with floor, then bias, wrapped to 16 bits
    function automatic logic [15:0] scale_to_dac(longint x, logic [15:0] gain);
        longint y;
        y = ((x * longint'(gain)) >>> 16) + longint'(bias_level);
        return y[15:0];
    endfunction

    task automatic reset_model();
        fmt_cfg    = pfvf_pkg::FMT_16_STEREO;
        mono_mix   = 1'b0;
        step_cfg   = pfvf_pkg::STEP_RESET;
        gain_l     = pfvf_pkg::GAIN_RESET;
        gain_r     = pfvf_pkg::GAIN_RESET;
        track_bias = 1'b0;
        phase_acc  = '0;
        fading     = 1'b1;
        bias_level = '0;
        expected_words.delete();
    endtask

    task automatic write_setting(logic [pfvf_pkg::CFG_INDEX_BITS-1:0] idx,
                                 logic [31:0] data);
        case (idx)
            pfvf_pkg::CFG_SAMPLE_FORMAT: fmt_cfg    = pfvf_pkg::t_format'(data[1:0]);
            pfvf_pkg::CFG_FORCE_MONO:    mono_mix   = data[0];
            pfvf_pkg::CFG_FADER_STEP:    step_cfg   = data;
            pfvf_pkg::CFG_GAIN_LEFT:     gain_l     = data[15:0];
            pfvf_pkg::CFG_GAIN_RIGHT:    gain_r     = data[15:0];
            pfvf_pkg::CFG_INTERNAL_DAC:  track_bias = data[0];
            default: ;
        endcase
    endtask

    // Advance the fade state for one input item and queue its DAC words
    task automatic predict_dac_words(logic op, logic [15:0] wf, logic [15:0] ws);
        longint      left_s;
        longint      right_s;
        longint      high_s;
        logic [15:0] fade;
        bit          two_words;
        t_dac_word   word;
        two_words = 1'b0;
        high_s    = 0;
        left_s    = 0;
        right_s   = 0;
        if (op == pfvf_pkg::OP_TICK) begin
            // fade-out: ramp the bias down, or rearm the fade-in at the bottom
            if (phase_acc > step_cfg) begin
                bias_level       = curve_level(phase_acc);
                phase_acc        = phase_acc - step_cfg;
                word.left_word   = bias_level;
                word.right_word  = bias_level;
                word.last_of_run = 1'b1;
                expected_words.push_back(word);
            end else begin
                phase_acc  = '0;
                fading     = 1'b1;
                bias_level = '0;
            end
        end else begin
            // unpack the source item
            case (fmt_cfg)
                pfvf_pkg::FMT_8_MONO: begin
                    right_s   = (longint'(wf[7:0]) - 128) * 256;
                    left_s    = right_s;
                    high_s    = longint'({wf[15:8], 8'h00}) - 32768;
                    two_words = 1'b1;
                end
                pfvf_pkg::FMT_8_STEREO: begin
                    right_s = (longint'(wf[7:0]) - 128) * 256;
                    left_s  = longint'({wf[15:8], 8'h00}) - 32768;
                end
                pfvf_pkg::FMT_16_MONO: begin
                    right_s = longint'(signed'(wf));
                    left_s  = right_s;
                end
                default: begin
                    right_s = longint'(signed'(wf));
                    left_s  = longint'(signed'(ws));
                end
            endcase
            if (mono_mix && (fmt_cfg == pfvf_pkg::FMT_8_STEREO
                             || fmt_cfg == pfvf_pkg::FMT_16_STEREO)) begin
                right_s = (right_s + left_s) >>> 1;
                left_s  = right_s;
            end

            // fade-in: scale along the curve until the phase saturates
            if (fading) begin
                if (phase_acc < pfvf_pkg::PHASE_MAX - step_cfg) begin
                    fade      = curve_level(phase_acc);
                    phase_acc = phase_acc + step_cfg;
                    left_s    = (left_s * longint'(fade)) >>> 15;
                    right_s   = (right_s * longint'(fade)) >>> 15;
                end else begin
                    phase_acc = pfvf_pkg::PHASE_MAX;
                    fade      = pfvf_pkg::FADE_FULL;
                    fading    = 1'b0;
                end
                if (track_bias) begin
                    bias_level = fade;
                end
            end

            word.left_word   = scale_to_dac(left_s, gain_l);
            word.right_word  = scale_to_dac(right_s, gain_r);
            word.last_of_run = !two_words;
            expected_words.push_back(word);
            // 8-bit mono: high byte follows, unfaded
            if (two_words) begin
                word.left_word   = scale_to_dac(high_s, gain_l);
                word.right_word  = scale_to_dac(high_s, gain_r);
                word.last_of_run = 1'b1;
                expected_words.push_back(word);
            end
        end
    endtask

    task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %h, actual %h", name, want, got);
            fail_total++;
        end
    endtask

    task automatic check_dac_word();
        t_dac_word want;
        if (expected_words.size() == 0) begin
            $error("unexpected result transfer: left %h right %h last %b",
                   i_left_word, i_right_word, i_last_of_run);
            fail_total++;
        end else begin
            want = expected_words.pop_front();
            compare_field("left_word", want.left_word, i_left_word);
            compare_field("right_word", want.right_word, i_right_word);
            compare_field("last_of_run", 16'(want.last_of_run), 16'(i_last_of_run));
        end
    endtask

    // Sample all channels at the clock edge; check before predicting
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_model();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                write_setting(i_cfg_index, i_cfg_data);
            end
            if (i_out_valid && i_out_ready) begin
                check_dac_word();
            end
            if (i_in_valid && i_in_ready) begin
                predict_dac_words(i_opcode, i_word_first, i_word_second);
            end
        end
        o_pending    <= expected_words.size();
        o_fail_count <= fail_total;
    end

endmodule

// ===== test/tb_pcm_fade_volume_formatter_core.sv =====
// ----------------------------------------------------------------------------
// tb_pcm_fade_volume_formatter_core
// Drives sample items, fade-out ticks and register writes into the PCM fade
// and volume formatter with random idle cycles on both channels. A directed
// opening covers field extremes and step extremes, then random phases with
// fresh settings run bursts of samples and ticks. The checker predicts and
// compares; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_pcm_fade_volume_formatter_core;

    localparam int QUIET_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 100;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 146;
    localparam int BUSY_PHASE    = 4;

    // register indexes with no register behind them
    localparam logic [pfvf_pkg::CFG_INDEX_BITS-1:0] CFG_UNUSED_LO = 3'd6;
    localparam logic [pfvf_pkg::CFG_INDEX_BITS-1:0] CFG_UNUSED_HI = 3'd7;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        opcode      = pfvf_pkg::OP_SAMPLE;
    logic [15:0] word_first  = '0;
    logic [15:0] word_second = '0;
    logic        out_ready   = 1'b0;
    logic        cfg_valid   = 1'b0;
    logic [pfvf_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [31:0] cfg_data    = '0;
    logic        idle_on     = 1'b1;

    logic        in_ready;
    logic        out_valid;
    logic [15:0] left_word;
    logic [15:0] right_word;
    logic        last_of_run;
    logic        cfg_ready;

    int          fail_count;
    int          pending;
    int          quiet_cycles = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    pcm_fade_volume_formatter_core dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_opcode      (opcode),
        .i_word_first  (word_first),
        .i_word_second (word_second),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_left_word   (left_word),
        .o_right_word  (right_word),
        .o_last_of_run (last_of_run),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    pfvf_dac_word_checker result_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_opcode      (opcode),
        .i_word_first  (word_first),
        .i_word_second (word_second),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_left_word   (left_word),
        .i_right_word  (right_word),
        .i_last_of_run (last_of_run),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // Stall the result side at random
    always @(posedge clk) begin
        out_ready <= !(idle_on && ($urandom_range(99) < 23));
    end

    // Count cycles without any transfer
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
        $display("simulation failed");
        $finish;
    end

    function automatic logic [15:0] pick_word();
        case ($urandom_range(7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            4:       return {8'($urandom), 8'h80};
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_step();
        case ($urandom_range(7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h0000_0001;
            3:       return $urandom;
            4:       return 32'h0400_0000;
            default: return $urandom_range(32'h1000_0000, 32'h0010_0000);
        endcase
    endfunction

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(3))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Fill the bits above a register's width with noise half of the time
    function automatic logic [31:0] pad_bits(logic [31:0] v, int bits);
        if ($urandom_range(1) == 0) begin
            return v;
        end
        return ($urandom << bits) | v;
    endfunction

    // Hold valid until the item transfers; valid may drop only for a gap
    task automatic send_item(logic op, logic [15:0] wf, logic [15:0] ws);
        if (idle_on && ($urandom_range(99) < 23)) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < 23);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        word_first  <= wf;
        word_second <= ws;
        do @(posedge clk); while (!in_ready);
    endtask

    // Leave valid high after the transfer; the caller drops it
    task automatic write_reg(logic [pfvf_pkg::CFG_INDEX_BITS-1:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic set_config(pfvf_pkg::t_format fmt, logic mono, logic [31:0] step_val,
                              logic [15:0] gl, logic [15:0] gr, logic idac);
        write_reg(pfvf_pkg::CFG_SAMPLE_FORMAT, pad_bits(32'(fmt), 2));
        write_reg(pfvf_pkg::CFG_FORCE_MONO, pad_bits(32'(mono), 1));
        write_reg(pfvf_pkg::CFG_FADER_STEP, step_val);
        write_reg(pfvf_pkg::CFG_GAIN_LEFT, pad_bits(32'(gl), 16));
        write_reg(pfvf_pkg::CFG_GAIN_RIGHT, pad_bits(32'(gr), 16));
        write_reg(pfvf_pkg::CFG_INTERNAL_DAC, pad_bits(32'(idac), 1));
        cfg_valid <= 1'b0;
    endtask

    // Drop valid, wait for every predicted word, then let a tick finish
    task automatic settle_block();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin : stimulus
        int sent;
        int run;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: 16-bit stereo extremes, two ramp ticks, then a rearm
        send_item(pfvf_pkg::OP_SAMPLE, 16'h7FFF, 16'h8000);
        send_item(pfvf_pkg::OP_SAMPLE, 16'h8000, 16'h7FFF);
        send_item(pfvf_pkg::OP_SAMPLE, 16'h0000, 16'hFFFF);
        send_item(pfvf_pkg::OP_TICK, 16'h0000, 16'h0000);
        send_item(pfvf_pkg::OP_TICK, 16'hFFFF, 16'hFFFF);
        send_item(pfvf_pkg::OP_TICK, 16'h5A5A, 16'hA5A5);

        // zero step: fade-in never advances, a tick only rearms
        settle_block();
        write_reg(CFG_UNUSED_LO, $urandom);
        write_reg(CFG_UNUSED_HI, $urandom);
        set_config(pfvf_pkg::FMT_8_STEREO, 1'b1, 32'h0000_0000, 16'h0000, 16'hFFFF, 1'b1);
        send_item(pfvf_pkg::OP_SAMPLE, 16'hFFFF, 16'h0000);
        send_item(pfvf_pkg::OP_SAMPLE, 16'h0000, 16'hFFFF);
        send_item(pfvf_pkg::OP_TICK, 16'h8000, 16'h7FFF);

        // full step: fade-in ends on the first sample, mono ignores force_mono
        settle_block();
        set_config(pfvf_pkg::FMT_8_MONO, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, 16'h0000, 1'b1);
        send_item(pfvf_pkg::OP_SAMPLE, 16'hFF00, 16'h1234);
        send_item(pfvf_pkg::OP_SAMPLE, 16'h00FF, 16'h4321);
        send_item(pfvf_pkg::OP_SAMPLE, 16'h8080, 16'hFFFF);

        // 16-bit mono after the fade: ramp down from the top
        settle_block();
        set_config(pfvf_pkg::FMT_16_MONO, 1'b0, 32'h0400_0000, 16'h0000, 16'hFFFF, 1'b0);
        send_item(pfvf_pkg::OP_TICK, 16'h0000, 16'h0000);
        send_item(pfvf_pkg::OP_SAMPLE, 16'h7FFF, 16'h0000);
        send_item(pfvf_pkg::OP_SAMPLE, 16'h8000, 16'hFFFF);
        send_item(pfvf_pkg::OP_TICK, 16'hFFFF, 16'h0000);

        // near-full step: rearm, one faded sample, saturation, one tick, rearm
        settle_block();
        set_config(pfvf_pkg::FMT_16_STEREO, 1'b1, 32'hFFFF_FFFE, 16'hFFFF, 16'hFFFF, 1'b0);
        send_item(pfvf_pkg::OP_TICK, 16'h0000, 16'h0000);
        send_item(pfvf_pkg::OP_SAMPLE, 16'h7FFF, 16'h7FFF);
        send_item(pfvf_pkg::OP_SAMPLE, 16'h8000, 16'h8000);
        send_item(pfvf_pkg::OP_TICK, 16'h0000, 16'h0000);
        send_item(pfvf_pkg::OP_TICK, 16'h0000, 16'h0000);

        // random phases: bursts of samples with shorter bursts of ticks
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            settle_block();
            idle_on <= (ph != BUSY_PHASE);
            set_config(pfvf_pkg::t_format'($urandom_range(3)), 1'($urandom), pick_step(),
                       pick_gain(), pick_gain(), 1'($urandom));
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(99) < 80) begin
                    run = $urandom_range(24, 1);
                    repeat (run) send_item(pfvf_pkg::OP_SAMPLE, pick_word(), pick_word());
                end else begin
                    run = $urandom_range(10, 1);
                    repeat (run) send_item(pfvf_pkg::OP_TICK, 16'($urandom), 16'($urandom));
                end
                sent += run;
            end
        end

        settle_block();
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
